// File: rtl/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg: shared types and constants of the two-level page table engine
// Item layouts, field slicing, operation and status codes, store geometry.
// ----------------------------------------------------------------------------
package tlpt_pkg;

    localparam int DIR_ENTRIES       = 1024;
    localparam int ENTRIES_PER_TABLE = 1024;
    localparam int TABLE_SLOTS       = 8;

    localparam int IDX_W     = 10;
    localparam int OFS_W     = 12;
    localparam int FRAME_W   = 20;
    localparam int FLAG_W    = 12;
    localparam int DIR_SHIFT = 22;
    localparam int TBL_SHIFT = 12;

    localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int NF_W      = $clog2(TABLE_SLOTS + 1);
    localparam int TBL_AW    = SLOT_W + IDX_W;
    localparam int TBL_DEPTH = TABLE_SLOTS * ENTRIES_PER_TABLE;

    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = $clog2(Q_DEPTH);
    localparam int Q_LW    = $clog2(Q_DEPTH + 1);

    localparam int FL_PRESENT = 0;
    localparam int FL_USER    = 2;

    localparam logic [1:0] OP_XLATE = 2'd0;
    localparam logic [1:0] OP_MAP   = 2'd1;
    localparam logic [1:0] OP_UNMAP = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [1:0] ST_NO_SLOT    = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] virt_addr;
        logic [31:0] map_addr;
        logic [11:0] page_flags;
    } t_req;

    typedef struct packed {
        logic [31:0] phys_out;
        logic [1:0]  status;
    } t_rsp;

    typedef struct packed {
        logic [1:0]         op;
        logic [IDX_W-1:0]   didx;
        logic [IDX_W-1:0]   tidx;
        logic [OFS_W-1:0]   offset;
        logic [FRAME_W-1:0] frame;
        logic [FLAG_W-1:0]  flags;
    } t_cmd;

    typedef struct packed {
        logic              present;
        logic              writable;
        logic              user;
        logic [SLOT_W-1:0] slot;
    } t_dir;

endpackage

// File: rtl/tlpt_front.sv
// ----------------------------------------------------------------------------
// tlpt_front: request intake
// Splits each request into walk fields and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module tlpt_front import tlpt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd            r_q [Q_DEPTH];
    logic [Q_PW-1:0] r_wp;
    logic [Q_PW-1:0] r_rp;
    logic [Q_LW-1:0] r_cnt;
    t_cmd            w_cmd;
    logic            w_wr;
    logic            w_rd;

    always_comb begin
        w_cmd.op     = i_req.operation;
        w_cmd.didx   = i_req.virt_addr[DIR_SHIFT +: IDX_W];
        w_cmd.tidx   = i_req.virt_addr[TBL_SHIFT +: IDX_W];
        w_cmd.offset = i_req.virt_addr[OFS_W-1:0];
        w_cmd.frame  = i_req.map_addr[TBL_SHIFT +: FRAME_W];
        w_cmd.flags  = i_req.page_flags;
    end

    assign o_full  = (r_cnt == Q_LW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/tlpt_back.sv
// ----------------------------------------------------------------------------
// tlpt_back: page walk sequencer
// Owns the directory and table stores, clears them after reset, and runs
// directory read, table read or write back for one item at a time.
// ----------------------------------------------------------------------------
module tlpt_back import tlpt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  t_cmd            i_cmd,
    output logic            o_cmd_pop,
    input  logic [Q_LW-1:0] i_rsp_level,
    output logic            o_rsp_push,
    output t_rsp            o_rsp
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_DIR, S_TBL} t_state;

    t_state              r_state;
    t_state              n_state;
    t_cmd                r_cmd;
    logic [TBL_AW-1:0]   r_clr;
    logic [TBL_AW-1:0]   n_clr;
    logic [NF_W-1:0]     r_next_free;
    logic [NF_W-1:0]     n_next_free;

    t_dir                r_dir_mem [DIR_ENTRIES];
    logic [31:0]         r_tbl_mem [TBL_DEPTH];
    t_dir                r_dir_q;
    logic [31:0]         r_tbl_q;

    logic                dir_we;
    logic [IDX_W-1:0]    dir_waddr;
    t_dir                dir_wdata;
    logic                tbl_we;
    logic [TBL_AW-1:0]   tbl_waddr;
    logic [31:0]         tbl_wdata;
    logic [TBL_AW-1:0]   tbl_raddr;

    logic                w_free;
    logic [SLOT_W-1:0]   w_new_slot;
    logic                w_emit;
    logic                w_go_tbl;
    logic                w_alloc;
    logic                w_room;
    logic                w_take;
    t_rsp                w_rsp;

    assign w_free     = (r_next_free < NF_W'(TABLE_SLOTS));
    assign w_new_slot = r_next_free[SLOT_W-1:0];
    assign tbl_raddr  = {r_dir_q.slot, r_cmd.tidx};

    always_comb begin
        dir_we         = 1'b0;
        dir_waddr      = r_cmd.didx;
        dir_wdata      = '0;
        tbl_we         = 1'b0;
        tbl_waddr      = {r_dir_q.slot, r_cmd.tidx};
        tbl_wdata      = '0;
        w_emit         = 1'b0;
        w_go_tbl       = 1'b0;
        w_alloc        = 1'b0;
        w_rsp.phys_out = '0;
        w_rsp.status   = ST_OK;
        unique case (r_state)
            S_CLEAR: begin
                dir_we    = 1'b1;
                dir_waddr = r_clr[IDX_W-1:0];
                tbl_we    = 1'b1;
                tbl_waddr = r_clr;
            end
            S_IDLE: begin
            end
            S_DIR: begin
                unique case (r_cmd.op)
                    OP_XLATE: begin
                        if (r_dir_q.present) begin
                            w_go_tbl = 1'b1;
                        end else begin
                            w_emit       = 1'b1;
                            w_rsp.status = ST_NOT_MAPPED;
                        end
                    end
                    OP_MAP: begin
                        w_emit    = 1'b1;
                        tbl_wdata = {r_cmd.frame, r_cmd.flags | FLAG_W'(1)};
                        if (r_dir_q.present) begin
                            tbl_we = 1'b1;
                        end else if (w_free) begin
                            w_alloc            = 1'b1;
                            dir_we             = 1'b1;
                            dir_wdata.present  = 1'b1;
                            dir_wdata.writable = 1'b1;
                            dir_wdata.user     = r_cmd.flags[FL_USER];
                            dir_wdata.slot     = w_new_slot;
                            tbl_we             = 1'b1;
                            tbl_waddr          = {w_new_slot, r_cmd.tidx};
                        end else begin
                            w_rsp.status = ST_NO_SLOT;
                        end
                    end
                    OP_UNMAP: begin
                        w_emit = 1'b1;
                        if (r_dir_q.present) begin
                            tbl_we = 1'b1;
                        end else begin
                            w_rsp.status = ST_NOT_MAPPED;
                        end
                    end
                    default: begin
                        w_emit = 1'b1;
                    end
                endcase
            end
            S_TBL: begin
                w_emit = 1'b1;
                if (r_tbl_q[FL_PRESENT]) begin
                    w_rsp.phys_out = {r_tbl_q[31:OFS_W], r_cmd.offset};
                end else begin
                    w_rsp.status = ST_NOT_MAPPED;
                end
            end
            default: begin
            end
        endcase
    end

    // a result pushed this cycle still occupies a queue slot
    assign w_room = w_emit ? (i_rsp_level == '0) : (i_rsp_level != Q_LW'(Q_DEPTH));
    assign w_take = ((r_state == S_IDLE) || w_emit) && i_cmd_valid && w_room;

    assign o_cmd_pop  = w_take;
    assign o_rsp_push = w_emit;
    assign o_rsp      = w_rsp;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_next_free = r_next_free;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == TBL_AW'(TBL_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_take) begin
                    n_state = S_DIR;
                end
            end
            S_DIR, S_TBL: begin
                if (w_alloc) begin
                    n_next_free = r_next_free + 1'b1;
                end
                if (w_go_tbl) begin
                    n_state = S_TBL;
                end else if (w_take) begin
                    n_state = S_DIR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_next_free <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_next_free <= n_next_free;
            if (w_take) begin
                r_cmd <= i_cmd;
            end
        end
    end

    // directory store, write-first for a same-cycle read of the same entry
    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            r_dir_mem[dir_waddr] <= dir_wdata;
        end
        if (dir_we && (dir_waddr == i_cmd.didx)) begin
            r_dir_q <= dir_wdata;
        end else begin
            r_dir_q <= r_dir_mem[i_cmd.didx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        r_tbl_q <= r_tbl_mem[tbl_raddr];
    end

endmodule

// File: rtl/tlpt_rq.sv
// ----------------------------------------------------------------------------
// tlpt_rq: result queue
// Two-entry queue that parts the walk sequencer from the result consumer.
// ----------------------------------------------------------------------------
module tlpt_rq import tlpt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t_rsp            i_rsp,
    output logic [Q_LW-1:0] o_level,
    output logic            o_empty,
    input  logic            i_pop,
    output t_rsp            o_rsp
);

    t_rsp            r_q [Q_DEPTH];
    logic [Q_PW-1:0] r_wp;
    logic [Q_PW-1:0] r_rp;
    logic [Q_LW-1:0] r_cnt;
    logic            w_wr;
    logic            w_rd;

    assign o_level = r_cnt;
    assign o_empty = (r_cnt == '0);
    assign o_rsp   = r_q[r_rp];
    assign w_wr    = i_push && (r_cnt != Q_LW'(Q_DEPTH));
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= i_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/two_level_page_table_engine_core.sv
// ----------------------------------------------------------------------------
// two_level_page_table_engine_core: two-level page table engine
// Translates, maps and unmaps 32-bit virtual addresses through one page
// directory and a pool of second-level tables.
// ----------------------------------------------------------------------------
//  channel   handshake          payload  item
//  request   push / full        i_req    operation, virt_addr, map_addr, flags
//  result    empty / pop        o_rsp    phys_out, status
//
//  Map and unmap write the table in the directory read state; a translate
//  through a present directory entry adds a table read state. After reset
//  a clearing pass over TABLE_SLOTS*1024 (8192) table entries zeroes both
//  stores; requests queue up (two deep) but are not walked until it ends.
//  A waiting result sends the walker through its idle state between items;
//  two waiting results hold the walker.
// ----------------------------------------------------------------------------
module two_level_page_table_engine_core import tlpt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_req i_req,
    output logic empty,
    input  logic pop,
    output t_rsp o_rsp
);

    logic            cmd_valid;
    logic            cmd_pop;
    t_cmd            cmd;
    logic            rsp_push;
    t_rsp            rsp;
    logic [Q_LW-1:0] rsp_level;

    tlpt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_req   (i_req),
        .o_valid (cmd_valid),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd)
    );

    tlpt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_rsp_level (rsp_level),
        .o_rsp_push  (rsp_push),
        .o_rsp       (rsp)
    );

    tlpt_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rsp_push),
        .i_rsp   (rsp),
        .o_level (rsp_level),
        .o_empty (empty),
        .i_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

// File: rtl/tlpt_chk.sv
// ----------------------------------------------------------------------------
// tlpt_chk: port checks for the page table engine
// Watches the result side of the top level over time.
// ----------------------------------------------------------------------------
module tlpt_chk import tlpt_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic empty,
    input logic pop,
    input t_rsp o_rsp
);

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_rsp.status == ST_OK || o_rsp.status == ST_NOT_MAPPED ||
                    o_rsp.status == ST_NO_SLOT))
        else $error("result status code out of range");

    a_addr_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_rsp.phys_out != '0)) |-> (o_rsp.status == ST_OK))
        else $error("address returned with a failing status");

    a_empty_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result waiting straight after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_rsp)))
        else $error("waiting result changed before it was taken");

endmodule

bind two_level_page_table_engine_core tlpt_chk u_chk (.*);
